// ===== hdl/cau_pkg.sv =====
// Shared operation and status codes for the complex arithmetic unit.
package cau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

endpackage

// ===== hdl/cau_if.sv =====
// Valid/ready channel interfaces for operand requests and results.
interface cau_req_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;

    modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_res_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic [1:0]                   status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

// ===== hdl/cau_front.sv =====
// Front stages: operand products, sums and the direct add/sub/multiply value.
module cau_front #(
    parameter int W = 16,
    parameter int F = 8
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  cau_pkg::t_op         i_op,
    input  logic signed [W-1:0]  i_a_re,
    input  logic signed [W-1:0]  i_a_im,
    input  logic signed [W-1:0]  i_b_re,
    input  logic signed [W-1:0]  i_b_im,
    output cau_pkg::t_op         o_op,
    output logic signed [2*W:0]  o_dir_re,
    output logic signed [2*W:0]  o_dir_im,
    output logic signed [2*W:0]  o_num_re,
    output logic signed [2*W:0]  o_num_im,
    output logic [2*W-1:0]       o_den
);
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;

    logic signed [PW-1:0] w_rr, w_ii, w_ri, w_ir, w_br2, w_bi2;
    logic signed [W:0]    w_s_re, w_s_im;

    cau_pkg::t_op         r_op;
    logic signed [PW-1:0] r_rr, r_ii, r_ri, r_ir, r_br2, r_bi2;
    logic signed [W:0]    r_s_re, r_s_im;

    logic signed [SW-1:0] w_m_re, w_m_im;

    assign w_rr  = i_a_re * i_b_re;
    assign w_ii  = i_a_im * i_b_im;
    assign w_ri  = i_a_re * i_b_im;
    assign w_ir  = i_a_im * i_b_re;
    assign w_br2 = i_b_re * i_b_re;
    assign w_bi2 = i_b_im * i_b_im;

    assign w_s_re = (i_op == cau_pkg::OP_SUB) ? (i_a_re - i_b_re) : (i_a_re + i_b_re);
    assign w_s_im = (i_op == cau_pkg::OP_SUB) ? (i_a_im - i_b_im) : (i_a_im + i_b_im);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op   <= i_op;
            r_rr   <= w_rr;
            r_ii   <= w_ii;
            r_ri   <= w_ri;
            r_ir   <= w_ir;
            r_br2  <= w_br2;
            r_bi2  <= w_bi2;
            r_s_re <= w_s_re;
            r_s_im <= w_s_im;
        end
    end

    assign w_m_re = SW'(r_rr) - SW'(r_ii);
    assign w_m_im = SW'(r_ri) + SW'(r_ir);

    // Second stage: cross sums, divisor and the direct value (floor-shifted product or add/sub sum).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_op     <= r_op;
            o_num_re <= SW'(r_rr) + SW'(r_ii);
            o_num_im <= SW'(r_ir) - SW'(r_ri);
            o_den    <= PW'($unsigned(r_br2) + $unsigned(r_bi2));
            o_dir_re <= (r_op == cau_pkg::OP_MUL) ? (w_m_re >>> F) : SW'(r_s_re);
            o_dir_im <= (r_op == cau_pkg::OP_MUL) ? (w_m_im >>> F) : SW'(r_s_im);
        end
    end
endmodule

// ===== hdl/cau_div_step.sv =====
// One registered restoring-division step: resolves a single quotient bit.
module cau_div_step #(
    parameter int W   = 16,
    parameter int F   = 8,
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [2*W-1:0]       i_den,
    input  logic [2*W+F-1:0]     i_rem,
    input  logic [W:0]           i_q,
    input  logic                 i_neg,
    input  logic                 i_ovf,
    output logic [2*W+F-1:0]     o_rem,
    output logic [W:0]           o_q,
    output logic                 o_neg,
    output logic                 o_ovf
);
    localparam int RW = 2 * W + F;
    localparam int QB = W + 1;
    localparam int CW = 2 * W + F + QB;

    logic [CW-1:0] w_trial;
    logic [CW-1:0] w_rem;
    logic          w_fit;
    logic [RW-1:0] n_rem;
    logic [QB-1:0] n_q;

    assign w_trial = CW'(i_den) << BIT;
    assign w_rem   = CW'(i_rem);
    assign w_fit   = (w_rem >= w_trial);

    always_comb begin
        n_rem = i_rem;
        n_q   = i_q;
        if (w_fit) begin
            n_rem    = RW'(w_rem - w_trial);
            n_q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_q   <= n_q;
            o_neg <= i_neg;
            o_ovf <= i_ovf;
        end
    end
endmodule

// ===== hdl/cau_div.sv =====
// Pipelined signed divider: (num << F) / den for both parts, one quotient bit a stage.
module cau_div #(
    parameter int W = 16,
    parameter int F = 8
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [2*W:0]  i_num_re,
    input  logic signed [2*W:0]  i_num_im,
    input  logic [2*W-1:0]       i_den,
    output logic signed [W+1:0]  o_q_re,
    output logic signed [W+1:0]  o_q_im,
    output logic                 o_ovf_re,
    output logic                 o_ovf_im,
    output logic                 o_neg_re,
    output logic                 o_neg_im
);
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int RW = 2 * W + F;
    localparam int QB = W + 1;
    localparam int CW = 2 * W + F + QB;

    logic signed [SW-1:0] w_abs_re, w_abs_im;
    logic [RW-1:0]        w_sc_re, w_sc_im;

    logic [PW-1:0] r_den [0:QB-1];
    logic [RW-1:0] w_rem_re [0:QB-1];
    logic [RW-1:0] w_rem_im [0:QB-1];
    logic [QB-1:0] w_q_re [0:QB];
    logic [QB-1:0] w_q_im [0:QB];
    logic          w_neg_re [0:QB];
    logic          w_neg_im [0:QB];
    logic          w_ovf_re [0:QB];
    logic          w_ovf_im [0:QB];

    assign w_abs_re = i_num_re[SW-1] ? -i_num_re : i_num_re;
    assign w_abs_im = i_num_im[SW-1] ? -i_num_im : i_num_im;
    assign w_sc_re  = RW'(w_abs_re[PW-1:0]) << F;
    assign w_sc_im  = RW'(w_abs_im[PW-1:0]) << F;

    // Prepare: magnitude, sign and an early check that the quotient overflows.
    logic [RW-1:0] r_rem_re0, r_rem_im0;
    logic          r_neg_re0, r_neg_im0, r_ovf_re0, r_ovf_im0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_re0 <= w_sc_re;
            r_rem_im0 <= w_sc_im;
            r_neg_re0 <= i_num_re[SW-1];
            r_neg_im0 <= i_num_im[SW-1];
            r_ovf_re0 <= (CW'(w_sc_re) >= (CW'(i_den) << QB));
            r_ovf_im0 <= (CW'(w_sc_im) >= (CW'(i_den) << QB));
            r_den[0]  <= i_den;
            for (int k = 1; k < QB; k++) begin
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign w_rem_re[0] = r_rem_re0;
    assign w_rem_im[0] = r_rem_im0;
    assign w_q_re[0]   = '0;
    assign w_q_im[0]   = '0;
    assign w_neg_re[0] = r_neg_re0;
    assign w_neg_im[0] = r_neg_im0;
    assign w_ovf_re[0] = r_ovf_re0;
    assign w_ovf_im[0] = r_ovf_im0;

    for (genvar g = 0; g < QB; g++) begin : g_step
        logic [RW-1:0] w_nrem_re, w_nrem_im;

        cau_div_step #(.W(W), .F(F), .BIT(QB - 1 - g)) u_re (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_den (r_den[g]),
            .i_rem (w_rem_re[g]),
            .i_q   (w_q_re[g]),
            .i_neg (w_neg_re[g]),
            .i_ovf (w_ovf_re[g]),
            .o_rem (w_nrem_re),
            .o_q   (w_q_re[g+1]),
            .o_neg (w_neg_re[g+1]),
            .o_ovf (w_ovf_re[g+1])
        );

        cau_div_step #(.W(W), .F(F), .BIT(QB - 1 - g)) u_im (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_den (r_den[g]),
            .i_rem (w_rem_im[g]),
            .i_q   (w_q_im[g]),
            .i_neg (w_neg_im[g]),
            .i_ovf (w_ovf_im[g]),
            .o_rem (w_nrem_im),
            .o_q   (w_q_im[g+1]),
            .o_neg (w_neg_im[g+1]),
            .o_ovf (w_ovf_im[g+1])
        );

        if (g < QB - 1) begin : g_link
            assign w_rem_re[g+1] = w_nrem_re;
            assign w_rem_im[g+1] = w_nrem_im;
        end
    end

    assign o_q_re   = w_neg_re[QB] ? -$signed({1'b0, w_q_re[QB]}) : $signed({1'b0, w_q_re[QB]});
    assign o_q_im   = w_neg_im[QB] ? -$signed({1'b0, w_q_im[QB]}) : $signed({1'b0, w_q_im[QB]});
    assign o_ovf_re = w_ovf_re[QB];
    assign o_ovf_im = w_ovf_im[QB];
    assign o_neg_re = w_neg_re[QB];
    assign o_neg_im = w_neg_im[QB];
endmodule

// ===== hdl/complex_arith_unit.sv =====
// Top level of the pipelined complex add/subtract/multiply/divide unit.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  i_req   | in  | valid / ready      | req_type, a_re, a_im, b_re, b_im
//  o_res   | out | valid / ready      | res_re, res_im, status
//
// Takes one request every cycle while the output is not stalled; the divider
// resolves one quotient bit per stage for DATA_WIDTH + 1 stages.
// Every operation runs down the same pipe so results leave in request order.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
// A stall at the output freezes the whole pipe; nothing is dropped or repeated.
module complex_arith_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    cau_req_if.sink   i_req,
    cau_res_if.source o_res
);
    localparam int W      = DATA_WIDTH;
    localparam int SW     = 2 * W + 1;
    localparam int QB     = W + 1;
    localparam int L      = QB + 4;
    localparam int SIDE_W = 3 + 2 * SW;

    localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

    // Clamp to the output range; top bit flags that clamping happened.
    function automatic logic [W:0] f_clamp(input logic signed [SW-1:0] v);
        logic [W:0] res;
        if (v > MAXV) begin
            res = {1'b1, MAXV[W-1:0]};
        end else if (v < MINV) begin
            res = {1'b1, MINV[W-1:0]};
        end else begin
            res = {1'b0, v[W-1:0]};
        end
        return res;
    endfunction

    logic         w_en;
    logic [L-1:0] r_vld;

    // Advance everything unless a finished result is waiting to be taken.
    assign w_en        = !r_vld[L-1] || o_res.ready;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_req.valid};
        end
    end

    // Front: products and direct results.
    cau_pkg::t_op         w_op;
    logic signed [SW-1:0] w_dir_re, w_dir_im, w_num_re, w_num_im;
    logic [2*W-1:0]       w_den;

    cau_front #(.W(W), .F(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_op     (cau_pkg::t_op'(i_req.req_type)),
        .i_a_re   (i_req.a_re),
        .i_a_im   (i_req.a_im),
        .i_b_re   (i_req.b_re),
        .i_b_im   (i_req.b_im),
        .o_op     (w_op),
        .o_dir_re (w_dir_re),
        .o_dir_im (w_dir_im),
        .o_num_re (w_num_re),
        .o_num_im (w_num_im),
        .o_den    (w_den)
    );

    // Divider runs on every request; the final stage picks what applies.
    logic signed [QB:0] w_q_re, w_q_im;
    logic               w_ovf_re, w_ovf_im, w_neg_re, w_neg_im;

    cau_div #(.W(W), .F(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_num_re (w_num_re),
        .i_num_im (w_num_im),
        .i_den    (w_den),
        .o_q_re   (w_q_re),
        .o_q_im   (w_q_im),
        .o_ovf_re (w_ovf_re),
        .o_ovf_im (w_ovf_im),
        .o_neg_re (w_neg_re),
        .o_neg_im (w_neg_im)
    );

    // Side delay: carry opcode, zero-divisor flag and direct values alongside.
    logic [SIDE_W-1:0] r_side [0:QB];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= {w_op, (w_den == '0), w_dir_re, w_dir_im};
            for (int k = 1; k <= QB; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    cau_pkg::t_op         w_s_op;
    logic                 w_s_dz;
    logic signed [SW-1:0] w_s_re, w_s_im;

    assign w_s_op = cau_pkg::t_op'(r_side[QB][SIDE_W-1 -: 2]);
    assign w_s_dz = r_side[QB][2*SW];
    assign w_s_re = r_side[QB][2*SW-1 -: SW];
    assign w_s_im = r_side[QB][SW-1:0];

    // Final stage: saturate, pick the operation's value, form the status.
    logic [W:0]            w_c_re, w_c_im;
    logic signed [W-1:0]   n_res_re, n_res_im;
    cau_pkg::t_status      n_status;
    logic signed [W-1:0]   r_res_re, r_res_im;
    cau_pkg::t_status      r_status;

    always_comb begin
        case (w_s_op)
            cau_pkg::OP_DIV: begin
                w_c_re = w_ovf_re ? {1'b1, (w_neg_re ? MINV[W-1:0] : MAXV[W-1:0])}
                                  : f_clamp(SW'(w_q_re));
                w_c_im = w_ovf_im ? {1'b1, (w_neg_im ? MINV[W-1:0] : MAXV[W-1:0])}
                                  : f_clamp(SW'(w_q_im));
            end
            default: begin
                w_c_re = f_clamp(w_s_re);
                w_c_im = f_clamp(w_s_im);
            end
        endcase

        n_res_re = w_c_re[W-1:0];
        n_res_im = w_c_im[W-1:0];
        n_status = (w_c_re[W] || w_c_im[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        if (w_s_op == cau_pkg::OP_DIV && w_s_dz) begin
            n_res_re = '0;
            n_res_im = '0;
            n_status = cau_pkg::ST_DIV0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res_re <= n_res_re;
            r_res_im <= n_res_im;
            r_status <= n_status;
        end
    end

    assign o_res.valid  = r_vld[L-1];
    assign o_res.res_re = r_res_re;
    assign o_res.res_im = r_res_im;
    assign o_res.status = r_status;

    // Checks on the pipe's own behavior.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_req.ready)
        else $error("request side stalled with no result pending");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == cau_pkg::ST_DIV0) |->
        (o_res.res_re == '0 && o_res.res_im == '0))
        else $error("divide-by-zero result not zero");

    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == cau_pkg::ST_SAT) |->
        (o_res.res_re == MAXV[W-1:0] || o_res.res_re == MINV[W-1:0] ||
         o_res.res_im == MAXV[W-1:0] || o_res.res_im == MINV[W-1:0]))
        else $error("saturated status without a part at a bound");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> $stable(r_vld))
        else $error("pipe moved during an output stall");
endmodule

// ===== test/cau_checker.sv =====
// Checker for the complex arithmetic unit: predicts results and compares them.
`timescale 1ns / 1ps

module cau_checker #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cau_req_if.sink          i_req,
    cau_res_if.sink          i_res,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count
);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] re;
        logic signed [DATA_WIDTH-1:0] im;
        cau_pkg::t_status             status;
    } t_result;

    t_result expected_results[$];
    int      mismatches;
    int      results_seen;

    // Clamp to the signed range, flag when clamped.
    function automatic longint clamp_part(input longint x, inout bit sat);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (x < lo) begin
            sat = 1'b1;
            return lo;
        end
        return x;
    endfunction

    function automatic t_result compute_complex(input cau_pkg::t_op op,
                                                input longint ar, input longint ai,
                                                input longint br, input longint bi);
        t_result r;
        longint  re;
        longint  im;
        longint  d;
        bit      sat;
        re = 0;
        im = 0;
        sat = 1'b0;
        r.status = cau_pkg::ST_OK;
        case (op)
            cau_pkg::OP_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            cau_pkg::OP_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            cau_pkg::OP_MUL: begin
                // arithmetic shift floors toward minus infinity
                re = (ar * br - ai * bi) >>> FRAC_BITS;
                im = (ar * bi + ai * br) >>> FRAC_BITS;
            end
            default: begin
                d = br * br + bi * bi;
                if (d == 0) begin
                    r.status = cau_pkg::ST_DIV0;
                end else begin
                    // SV integer divide truncates toward zero
                    re = ((ar * br + ai * bi) * (longint'(1) <<< FRAC_BITS)) / d;
                    im = ((ai * br - ar * bi) * (longint'(1) <<< FRAC_BITS)) / d;
                end
            end
        endcase
        if (r.status == cau_pkg::ST_OK) begin
            re = clamp_part(re, sat);
            im = clamp_part(im, sat);
            if (sat) r.status = cau_pkg::ST_SAT;
        end
        r.re = re[DATA_WIDTH-1:0];
        r.im = im[DATA_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && i_req.valid && i_req.ready) begin
            expected_results.push_back(compute_complex(cau_pkg::t_op'(i_req.req_type),
                longint'(i_req.a_re), longint'(i_req.a_im),
                longint'(i_req.b_re), longint'(i_req.b_im)));
        end
        if (i_rst_n && i_res.valid && i_res.ready) begin
            got.re = i_res.res_re;
            got.im = i_res.res_im;
            got.status = cau_pkg::t_status'(i_res.status);
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("checker: unexpected result re=%0d im=%0d status=%0d",
                             got.re, got.im, got.status);
            end else begin
                want = expected_results.pop_front();
                if (got.re !== want.re || got.im !== want.im
                    || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"checker: mismatch exp re=%0d im=%0d st=%0d,",
                                  " got re=%0d im=%0d st=%0d"},
                                 want.re, want.im, want.status,
                                 got.re, got.im, got.status);
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        results_seen = 0;
    end

    assign o_fail_count   = mismatches;
    assign o_pending      = expected_results.size();
    assign o_result_count = results_seen;

endmodule

// ===== test/testbench.sv =====
// Stimulus and verdict for the complex arithmetic unit.
`timescale 1ns / 1ps

module testbench;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;
    localparam int LATENCY    = DATA_WIDTH + 5;
    localparam int RANDOM_REQUESTS = 1130;
    localparam longint CYCLE_LIMIT = 400000;

    logic   i_clk;
    logic   i_rst_n;
    int     fail_count;
    int     pending;
    int     result_count;
    longint cycle_count;
    int     op_counts[4];

    cau_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
    cau_res_if #(.DATA_WIDTH(DATA_WIDTH)) res_ch ();

    complex_arith_unit #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source)
    );

    cau_checker #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch.sink),
        .i_res         (res_ch.sink),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Hard stop so a hung handshake cannot run forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: cycle limit hit");
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, with gap-free stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random operand with bias toward the range extremes, zero and small values.
    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return '0;
            3: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Drive the result ready with random stalls, independent of the sender.
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    // Hold one request on the channel until it is accepted, then drop valid
    // only if a gap follows.
    task automatic send_request(input cau_pkg::t_op op, input logic [DATA_WIDTH-1:0] ar,
                                input logic [DATA_WIDTH-1:0] ai,
                                input logic [DATA_WIDTH-1:0] br,
                                input logic [DATA_WIDTH-1:0] bi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.a_re     <= ar;
        req_ch.a_im     <= ai;
        req_ch.b_re     <= br;
        req_ch.b_im     <= bi;
        op_counts[op]++;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    initial begin
        int waited;
        cycle_count      = 0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = cau_pkg::OP_ADD;
        req_ch.a_re      = '0;
        req_ch.a_im      = '0;
        req_ch.b_re      = '0;
        req_ch.b_im      = '0;
        i_rst_n          = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, each operation, divide by zero, saturation.
        send_request(cau_pkg::OP_ADD, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_request(cau_pkg::OP_ADD, 16'h0100, 16'hFF00, 16'h0001, 16'hFFFF);
        send_request(cau_pkg::OP_SUB, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_request(cau_pkg::OP_SUB, 16'h1234, 16'h5678, 16'h1234, 16'h5678);
        send_request(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_request(cau_pkg::OP_MUL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_request(cau_pkg::OP_MUL, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000);
        send_request(cau_pkg::OP_MUL, 16'h0100, 16'h0200, 16'h0300, 16'hFF00);
        send_request(cau_pkg::OP_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
        send_request(cau_pkg::OP_DIV, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
        send_request(cau_pkg::OP_DIV, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000);
        send_request(cau_pkg::OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF);
        send_request(cau_pkg::OP_DIV, 16'hFFFF, 16'h0001, 16'h0300, 16'h0000);
        send_request(cau_pkg::OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_request(cau_pkg::OP_DIV, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_request(cau_pkg::OP_DIV, 16'h0200, 16'hFD00, 16'h0100, 16'h0100);
        send_request(cau_pkg::OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // Random operations over biased operands.
        repeat (RANDOM_REQUESTS) begin
            send_request(cau_pkg::t_op'($urandom_range(0, 3)), pick_operand(),
                         pick_operand(), pick_operand(), pick_operand());
        end
        req_ch.valid <= 1'b0;

        // Drain, then let the pipe settle.
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (2 * LATENCY) @(negedge i_clk);

        $display("testbench: %0d results checked (add %0d, sub %0d, mul %0d, div %0d)",
                 result_count, op_counts[cau_pkg::OP_ADD], op_counts[cau_pkg::OP_SUB],
                 op_counts[cau_pkg::OP_MUL], op_counts[cau_pkg::OP_DIV]);
        $display("testbench: %0d requests still unanswered, %0d mismatches",
                 pending, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/cau_pkg.sv
hdl/cau_if.sv
hdl/cau_front.sv
hdl/cau_div_step.sv
hdl/cau_div.sv
hdl/complex_arith_unit.sv
test/cau_checker.sv
test/testbench.sv
